@@ hw/rtl/angle_unwrap_integrator_top_defines.svh @@
// assertion macros for the angle unwrap integrator checker
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef ANGLE_UNWRAP_INTEGRATOR_TOP_DEFINES_SVH
`define ANGLE_UNWRAP_INTEGRATOR_TOP_DEFINES_SVH

// same-cycle implication, off during reset
`define AUI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("aui check failed");

// next-cycle implication, off during reset
`define AUI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("aui check failed");

`endif

@@ hw/rtl/aui_pkg.sv @@
// shared types, constants and the arctangent table for the angle unwrap integrator
// no dependencies
package aui_pkg;

    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_FRAC_BITS = 16;

    // shift from the port angle format up to q30
    localparam int SH        = 30 - ANGLE_FRAC_BITS;
    localparam int MOD_STEPS = 3;
    localparam int MAC_STEPS = 4;
    localparam int CNT_MAX_A = (CORDIC_STEPS > MOD_STEPS) ? CORDIC_STEPS : MOD_STEPS;
    localparam int CNT_MAX   = (CNT_MAX_A > MAC_STEPS) ? CNT_MAX_A : MAC_STEPS;
    localparam int CNT_W     = $clog2(CNT_MAX);

    localparam int RW = 32 + SH;   // magnitude of the scaled input angle
    localparam int QW = SH;        // quotient of the 2pi reduction
    localparam int ZW = 35;        // cordic angle register
    localparam int CW = 36;        // cordic x and y registers
    localparam int AW = 33;        // cross and dot products

    localparam logic [33:0] TWO_PI_Q30  = 34'd6746518852;
    localparam logic [33:0] PI_Q30      = 34'd3373259426;
    localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
    localparam logic [33:0] GAIN_Q30    = 34'd652032874;
    localparam longint      STEP_HALF   = 64'sd1 <<< (SH - 1);

    // reciprocal of 2pi for the quotient estimate, taken from the top SH + 2 bits
    // of the magnitude; the estimate is never high and at most one low
    localparam logic [SH-1:0] MOD_RECIP = SH'((64'd1 << (SH + 32)) / 64'(TWO_PI_Q30));

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_PAIR  = 2'd1;
    localparam logic [1:0] REQ_ANGLE = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] cos_in;
        logic signed [15:0] sin_in;
        logic signed [31:0] angle_in;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] total_angle;
        logic               saturated;
    } t_out_word;

    typedef struct packed {
        logic take;
        logic mod_step;
        logic wrap;
        logic fold;
        logic cordic;
        logic rot;
        logic round;
        logic mac;
        logic vec_load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req_type;
        logic       mod_last;
        logic       cor_last;
        logic       mac_last;
        logic       vec_zero;
        logic       out_busy;
    } t_sts;

    // round(atan(2^-i) * 2^30)
    function automatic logic [29:0] atan_q30(input logic [CNT_W-1:0] idx);
        logic [29:0] v;
        case (int'(idx))
            0:  v = 30'd843314857;
            1:  v = 30'd497837829;
            2:  v = 30'd263043837;
            3:  v = 30'd133525159;
            4:  v = 30'd67021687;
            5:  v = 30'd33543516;
            6:  v = 30'd16775851;
            7:  v = 30'd8388437;
            8:  v = 30'd4194283;
            9:  v = 30'd2097149;
            10: v = 30'd1048576;
            11: v = 30'd524288;
            12: v = 30'd262144;
            13: v = 30'd131072;
            14: v = 30'd65536;
            15: v = 30'd32768;
            16: v = 30'd16384;
            17: v = 30'd8192;
            18: v = 30'd4096;
            19: v = 30'd2048;
            20: v = 30'd1024;
            21: v = 30'd512;
            22: v = 30'd256;
            23: v = 30'd128;
            24: v = 30'd64;
            25: v = 30'd32;
            26: v = 30'd16;
            27: v = 30'd8;
            28: v = 30'd4;
            29: v = 30'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ hw/rtl/aui_cordic.sv @@
// one cordic micro-rotation, rotation or vectoring mode
// depends on aui_pkg
module aui_cordic
    import aui_pkg::*;
(
    input  logic                 i_rot,
    input  logic [CNT_W-1:0]     i_idx,
    input  logic signed [CW-1:0] i_x,
    input  logic signed [CW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [ZW-1:0] o_z
);

    logic                 ccw;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic signed [ZW-1:0] ang;

    assign xs  = i_x >>> i_idx;
    assign ys  = i_y >>> i_idx;
    assign ang = signed'({{(ZW - 30){1'b0}}, atan_q30(i_idx)});

    // rotation drives z toward zero, vectoring drives y toward zero
    assign ccw = i_rot ? !i_z[ZW-1] : i_y[CW-1];

    assign o_x = ccw ? i_x - ys  : i_x + ys;
    assign o_y = ccw ? i_y + xs  : i_y - xs;
    assign o_z = ccw ? i_z - ang : i_z + ang;

endmodule

@@ hw/rtl/aui_dp.sv @@
// datapath: 2pi reduction, shared cordic, products, accumulator and output register
// depends on aui_pkg and aui_cordic
module aui_dp
    import aui_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_word  i_in_word,
    input  logic      i_out_ready,
    output t_sts      o_sts,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    localparam logic signed [ZW-1:0] Z_PI       = signed'(ZW'(PI_Q30));
    localparam logic signed [ZW-1:0] Z_HALF_PI  = signed'(ZW'(HALF_PI_Q30));
    localparam logic signed [ZW-1:0] Z_TWO_PI   = signed'(ZW'(TWO_PI_Q30));
    localparam logic signed [ZW-1:0] Z_STEP_RND = ZW'(STEP_HALF);
    localparam logic signed [CW-1:0] X_GAIN     = signed'(CW'(GAIN_Q30));
    localparam logic signed [CW-1:0] X_RND16    = CW'(32768);

    logic [1:0]           r_type;
    logic signed [31:0]   r_angle;
    logic signed [31:0]   r_accum;
    logic signed [15:0]   r_c;
    logic signed [15:0]   r_s;
    logic signed [15:0]   r_prev_cos;
    logic signed [15:0]   r_prev_sin;
    logic [RW-1:0]        r_rem;
    logic [QW-1:0]        r_q;
    logic                 r_neg;
    logic                 r_fold;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic signed [ZW-1:0] r_step;
    logic [CNT_W-1:0]     r_cnt;
    logic signed [AW-1:0] r_acc_sin;
    logic signed [AW-1:0] r_acc_cos;
    logic                 r_out_valid;
    t_out_word            r_out;

    logic signed [31:0]   n_accum;
    logic                 n_prev_wr;
    t_out_word            n_out;

    // input scaling to a q30 magnitude
    logic signed [RW-1:0] in_scaled;
    logic [RW-1:0]        in_mag;

    assign in_scaled = {i_in_word.angle_in, {SH{1'b0}}};
    assign in_mag    = in_scaled[RW-1] ? RW'(-in_scaled) : RW'(in_scaled);

    // 2pi reduction: quotient estimate, multiply back, one compare and subtract
    logic [2*SH+1:0] mod_est;
    logic [QW+33:0]  mod_prod;
    logic            mod_ge;

    assign mod_est  = (2*SH + 2)'(r_rem[RW-1:30]) * (2*SH + 2)'(MOD_RECIP);
    assign mod_prod = (QW + 34)'(r_q) * (QW + 34)'(TWO_PI_Q30);
    assign mod_ge   = r_rem >= RW'(TWO_PI_Q30);

    // floor remainder into (-pi, pi]
    logic [33:0]          wr_m0;
    logic [33:0]          wr_m1;
    logic signed [ZW-1:0] wr_z;

    assign wr_m0 = r_rem[33:0];
    assign wr_m1 = (r_neg && wr_m0 != '0) ? TWO_PI_Q30 - wr_m0 : wr_m0;
    assign wr_z  = (wr_m1 > PI_Q30) ? signed'(ZW'(wr_m1)) - Z_TWO_PI : signed'(ZW'(wr_m1));

    logic fold_hi;
    logic fold_lo;
    assign fold_hi = r_z > Z_HALF_PI;
    assign fold_lo = r_z < -Z_HALF_PI;

    // shared cordic
    logic signed [CW-1:0] cor_x;
    logic signed [CW-1:0] cor_y;
    logic signed [ZW-1:0] cor_z;

    aui_cordic u_cordic (
        .i_rot (i_cmd.rot),
        .i_idx (r_cnt),
        .i_x   (r_x),
        .i_y   (r_y),
        .i_z   (r_z),
        .o_x   (cor_x),
        .o_y   (cor_y),
        .o_z   (cor_z)
    );

    // rounding of the rotation result to q1.14
    function automatic logic signed [15:0] clamp16(input logic signed [CW-16:0] v);
        logic signed [15:0] r;
        if (v > (CW - 15)'(32767)) begin
            r = 16'sh7fff;
        end else if (v < -(CW - 15)'(32768)) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

    logic signed [CW-1:0]  rd_xt;
    logic signed [CW-1:0]  rd_yt;
    logic signed [CW-16:0] rd_x;
    logic signed [CW-16:0] rd_y;

    assign rd_xt = r_x + X_RND16;
    assign rd_yt = r_y + X_RND16;
    assign rd_x  = r_fold ? -{rd_xt[CW-1], rd_xt[CW-1:16]} : {rd_xt[CW-1], rd_xt[CW-1:16]};
    assign rd_y  = r_fold ? -{rd_yt[CW-1], rd_yt[CW-1:16]} : {rd_yt[CW-1], rd_yt[CW-1:16]};

    // mac order: s*pc, -c*ps, c*pc, +s*ps
    logic signed [15:0]   mac_a;
    logic signed [15:0]   mac_b;
    logic signed [31:0]   mac_p;
    logic signed [AW-1:0] mac_pe;

    assign mac_a  = (r_cnt[0] ^ r_cnt[1]) ? r_c : r_s;
    assign mac_b  = r_cnt[0] ? r_prev_sin : r_prev_cos;
    assign mac_p  = mac_a * mac_b;
    assign mac_pe = AW'(mac_p);

    logic signed [CW-1:0] vx;
    logic signed [CW-1:0] vy;
    assign vx = CW'(r_acc_cos);
    assign vy = CW'(r_acc_sin);

    logic signed [ZW-1:0] st_t;
    assign st_t = r_z + Z_STEP_RND;

    // accumulate with clamp at the 32-bit limits
    logic signed [ZW:0]   fin_sum;
    logic                 fin_ovf;
    logic signed [31:0]   fin_clamp;

    assign fin_sum   = (ZW + 1)'(r_accum) + (ZW + 1)'(r_step);
    assign fin_ovf   = !((&fin_sum[ZW:31]) || !(|fin_sum[ZW:31]));
    assign fin_clamp = fin_ovf ? (fin_sum[ZW] ? 32'sh80000000 : 32'sh7fffffff) : fin_sum[31:0];

    always_comb begin
        n_accum   = r_accum;
        n_prev_wr = 1'b0;
        n_out     = '{total_angle: r_accum, saturated: 1'b0};
        unique case (r_type)
            REQ_LOAD: begin
                n_accum   = r_angle;
                n_prev_wr = 1'b1;
                n_out     = '{total_angle: r_angle, saturated: 1'b0};
            end
            REQ_PAIR, REQ_ANGLE: begin
                n_accum   = fin_clamp;
                n_prev_wr = 1'b1;
                n_out     = '{total_angle: fin_clamp, saturated: fin_ovf};
            end
            default: begin
                n_accum   = r_accum;
                n_prev_wr = 1'b0;
            end
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum     <= '0;
            r_prev_cos  <= 16'sd16384;
            r_prev_sin  <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (i_cmd.finish) begin
                r_accum <= n_accum;
                if (n_prev_wr) begin
                    r_prev_cos <= r_c;
                    r_prev_sin <= r_s;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.take || i_cmd.wrap || i_cmd.fold || i_cmd.round || i_cmd.vec_load) begin
                r_cnt <= '0;
            end else if (i_cmd.mod_step || i_cmd.cordic || i_cmd.mac) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_type  <= i_in_word.req_type;
            r_angle <= i_in_word.angle_in;
            r_c     <= i_in_word.cos_in;
            r_s     <= i_in_word.sin_in;
            r_neg   <= i_in_word.angle_in[31];
            r_rem   <= in_mag;
        end
        if (i_cmd.mod_step) begin
            unique case (r_cnt)
                CNT_W'(0): r_q   <= mod_est[2*SH+1:SH+2];
                CNT_W'(1): r_rem <= r_rem - mod_prod[RW-1:0];
                default: begin
                    // the estimate may leave one 2pi too many
                    if (mod_ge) begin
                        r_rem <= r_rem - RW'(TWO_PI_Q30);
                    end
                end
            endcase
        end
        if (i_cmd.wrap) begin
            r_z <= wr_z;
        end
        if (i_cmd.fold) begin
            r_x    <= X_GAIN;
            r_y    <= '0;
            r_fold <= fold_hi || fold_lo;
            if (fold_hi) begin
                r_z <= r_z - Z_PI;
            end else if (fold_lo) begin
                r_z <= r_z + Z_PI;
            end
        end
        if (i_cmd.cordic) begin
            r_x <= cor_x;
            r_y <= cor_y;
            r_z <= cor_z;
        end
        if (i_cmd.round) begin
            r_c <= clamp16(rd_x);
            r_s <= clamp16(rd_y);
        end
        if (i_cmd.mac) begin
            unique case (r_cnt[1:0])
                2'd0:    r_acc_sin <= mac_pe;
                2'd1:    r_acc_sin <= r_acc_sin - mac_pe;
                2'd2:    r_acc_cos <= mac_pe;
                default: r_acc_cos <= r_acc_cos + mac_pe;
            endcase
        end
        if (i_cmd.vec_load) begin
            // quarter turn toward the x axis for a vector in the left half
            if (vx[CW-1]) begin
                if (!vy[CW-1]) begin
                    r_x <= vy;
                    r_y <= -vx;
                    r_z <= Z_HALF_PI;
                end else begin
                    r_x <= -vy;
                    r_y <= vx;
                    r_z <= -Z_HALF_PI;
                end
            end else begin
                r_x <= vx;
                r_y <= vy;
                r_z <= '0;
            end
        end
        if (i_cmd.step) begin
            r_step <= st_t >>> SH;
        end
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    assign o_sts.req_type = r_type;
    assign o_sts.mod_last = r_cnt == CNT_W'(MOD_STEPS - 1);
    assign o_sts.cor_last = r_cnt == CNT_W'(CORDIC_STEPS - 1);
    assign o_sts.mac_last = r_cnt == CNT_W'(MAC_STEPS - 1);
    assign o_sts.vec_zero = (r_acc_sin == '0) && (r_acc_cos == '0);
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

@@ hw/rtl/aui_ctrl.sv @@
// sequencer for the angle unwrap integrator datapath
// depends on aui_pkg
module aui_ctrl
    import aui_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_req_type,
    input  t_sts       i_sts,
    output logic       o_in_ready,
    output t_cmd       o_cmd
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_MOD   = 11'b000_0000_0010,
        S_WRAP  = 11'b000_0000_0100,
        S_FOLD  = 11'b000_0000_1000,
        S_ROT   = 11'b000_0001_0000,
        S_ROUND = 11'b000_0010_0000,
        S_MAC   = 11'b000_0100_0000,
        S_VPRE  = 11'b000_1000_0000,
        S_VEC   = 11'b001_0000_0000,
        S_STEP  = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    unique case (i_req_type)
                        REQ_LOAD, REQ_ANGLE: n_state = S_MOD;
                        REQ_PAIR:            n_state = S_MAC;
                        default:             n_state = S_DONE;
                    endcase
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_sts.mod_last) begin
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                o_cmd.wrap = 1'b1;
                n_state    = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                n_state    = S_ROT;
            end
            S_ROT: begin
                o_cmd.cordic = 1'b1;
                o_cmd.rot    = 1'b1;
                if (i_sts.cor_last) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = (i_sts.req_type == REQ_LOAD) ? S_DONE : S_MAC;
            end
            S_MAC: begin
                o_cmd.mac = 1'b1;
                if (i_sts.mac_last) begin
                    n_state = S_VPRE;
                end
            end
            S_VPRE: begin
                o_cmd.vec_load = 1'b1;
                // a null vector gives a zero step
                n_state = i_sts.vec_zero ? S_STEP : S_VEC;
            end
            S_VEC: begin
                o_cmd.cordic = 1'b1;
                if (i_sts.cor_last) begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ hw/rtl/angle_unwrap_integrator_top.sv @@
// channel  direction  handshake                  word
// input    in         i_in_valid / o_in_ready    t_in_word  (req_type, cos_in, sin_in, angle_in)
// output   out        o_out_valid / i_out_ready  t_out_word (total_angle, saturated)
//
// one word at a time: a new word is taken only when the sequencer is back in idle
// CORDIC_STEPS = 16 and a three-step 2pi reduction for load and angle update words
// a pair with a null vector skips the vectoring cordic
// the time per word is set by the shared cordic unit (one micro-rotation per cycle) and the
// reciprocal-multiply 2pi reduction of the input angle
// synchronous active-low reset: angle 0, stored pair (16384, 0), no result pending
// a finished result waits in the output register; a stalled output holds the
// sequencer in its last state while the next word is not yet taken
module angle_unwrap_integrator_top
    import aui_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word
);

    t_cmd cmd;
    t_sts sts;

    aui_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in_word.req_type),
        .i_sts      (sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    aui_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_word   (i_in_word),
        .i_out_ready (i_out_ready),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

@@ hw/rtl/aui_checker.sv @@
// port-level checks for the angle unwrap integrator, bound to the top level
// depends on aui_pkg and angle_unwrap_integrator_top_defines.svh
`include "angle_unwrap_integrator_top_defines.svh"

module aui_checker
    import aui_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_word o_out_word
);

    // a stalled result word holds
    `AUI_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_word))

    // one word in flight: the input closes right after an accept
    `AUI_ASSERT_NEXT(a_one_inflight, i_in_valid && o_in_ready, !o_in_ready)

    // a new result only appears after the sequencer was busy
    `AUI_ASSERT_NOW(a_out_after_busy, $rose(o_out_valid), !$past(o_in_ready))

    // a clamped sum sits on a range limit
    `AUI_ASSERT_NOW(a_sat_limit, o_out_valid && o_out_word.saturated, o_out_word.total_angle == 32'sh7fffffff || o_out_word.total_angle == 32'sh80000000)

endmodule

bind angle_unwrap_integrator_top aui_checker u_aui_checker (.*);

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for angle_unwrap_integrator_top: directed and random words
// against an in-file fixed point model of the unwrapped angle; depends on aui_pkg

import aui_pkg::*;

class unwrap_board;
    localparam int     FRAC_SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam int     ITERS      = (CORDIC_STEPS < 30) ? CORDIC_STEPS : 30;
    localparam longint PI_Q       = 64'sd3373259426;
    localparam longint TWO_PI_Q   = 64'sd6746518852;
    localparam longint HALF_PI_Q  = 64'sd1686629713;
    localparam longint GAIN_Q     = 64'sd652032874;
    localparam longint ANGLE_MAX  = 64'sd2147483647;
    localparam longint ANGLE_MIN  = -64'sd2147483648;

    longint             atan_tab [30];
    logic signed [31:0] accum;
    logic signed [15:0] last_cos;
    logic signed [15:0] last_sin;
    t_out_word          due_angles [$];
    int                 errors;

    function new();
        atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                     16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                     131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                     128, 64, 32, 16, 8, 4, 2};
        accum    = '0;
        last_cos = 16'sd16384;
        last_sin = '0;
        errors   = 0;
    endfunction

    function logic signed [15:0] sat16(input longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // rotation cordic on the angle folded into the right half plane
    function void unit_pair(input logic signed [31:0] a, output logic signed [15:0] c,
                            output logic signed [15:0] s);
        longint r;
        longint x;
        longint y;
        longint xn;
        bit     flip;
        r    = longint'(a) <<< FRAC_SHIFT;
        r    = r % TWO_PI_Q;
        flip = 1'b0;
        if (r < 0) r += TWO_PI_Q;
        if (r > PI_Q) r -= TWO_PI_Q;
        if (r > HALF_PI_Q) begin
            r -= PI_Q;
            flip = 1'b1;
        end else if (r < -HALF_PI_Q) begin
            r += PI_Q;
            flip = 1'b1;
        end
        x = GAIN_Q;
        y = 0;
        for (int i = 0; i < ITERS; i++) begin
            if (r >= 0) begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                r  = r - atan_tab[i];
            end else begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                r  = r + atan_tab[i];
            end
            x = xn;
        end
        x = (x + 32768) >>> 16;
        y = (y + 32768) >>> 16;
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = sat16(x);
        s = sat16(y);
    endfunction

    // vectoring cordic, left half plane turned by a quarter first
    function longint delta_q30(input longint y_in, input longint x_in);
        longint x;
        longint y;
        longint z;
        longint xn;
        x = x_in;
        y = y_in;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                x = y_in;
                y = -x_in;
                z = HALF_PI_Q;
            end else begin
                x = -y_in;
                y = x_in;
                z = -HALF_PI_Q;
            end
        end
        for (int i = 0; i < ITERS; i++) begin
            if (y >= 0) begin
                xn = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + atan_tab[i];
            end else begin
                xn = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - atan_tab[i];
            end
            x = xn;
        end
        return z;
    endfunction

    function t_out_word step_angle(input t_in_word w);
        t_out_word          res;
        logic signed [15:0] c;
        logic signed [15:0] s;
        longint             sin_d;
        longint             cos_d;
        longint             z;
        longint             sum;
        res.saturated = 1'b0;
        c = w.cos_in;
        s = w.sin_in;
        case (w.req_type)
            REQ_LOAD: begin
                accum = w.angle_in;
                unit_pair(w.angle_in, last_cos, last_sin);
            end
            REQ_PAIR, REQ_ANGLE: begin
                if (w.req_type == REQ_ANGLE) unit_pair(w.angle_in, c, s);
                sin_d = longint'(s) * longint'(last_cos) - longint'(c) * longint'(last_sin);
                cos_d = longint'(c) * longint'(last_cos) + longint'(s) * longint'(last_sin);
                z     = delta_q30(sin_d, cos_d);
                z     = (z + (64'sd1 <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
                sum   = longint'(accum) + z;
                if (sum > ANGLE_MAX) begin
                    sum = ANGLE_MAX;
                    res.saturated = 1'b1;
                end else if (sum < ANGLE_MIN) begin
                    sum = ANGLE_MIN;
                    res.saturated = 1'b1;
                end
                accum    = sum[31:0];
                last_cos = c;
                last_sin = s;
            end
            default: ;  // spare type leaves the state alone
        endcase
        res.total_angle = accum;
        return res;
    endfunction

    function void take_word(input t_in_word w);
        due_angles.push_back(step_angle(w));
    endfunction

    function void check_word(input t_out_word got);
        t_out_word want;
        if (due_angles.size() == 0) begin
            errors++;
            if (errors <= 10)
                $display("unexpected word: angle %0d sat %0b", got.total_angle, got.saturated);
            return;
        end
        want = due_angles.pop_front();
        if (got.total_angle !== want.total_angle || got.saturated !== want.saturated) begin
            errors++;
            if (errors <= 10)
                $display("mismatch: angle exp %0d got %0d, sat exp %0b got %0b",
                         want.total_angle, got.total_angle, want.saturated, got.saturated);
        end
    endfunction

    function int pending();
        return due_angles.size();
    endfunction
endclass

module tb;
    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int         N_RANDOM  = 700;

    logic      i_clk;
    logic      r_rst_n     = 1'b0;
    logic      r_in_valid  = 1'b0;
    t_in_word  r_in_word   = '0;
    logic      r_out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_word o_out_word;

    unwrap_board        sb = new();
    bit                 tx_calm = 1'b0;
    int                 n_sent  = 0;
    logic signed [31:0] walk    = '0;

    angle_unwrap_integrator_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (r_rst_n),
        .i_in_valid  (r_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (r_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (r_out_ready),
        .o_out_word  (o_out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // output words are checked before new input words at the same edge
    always @(posedge i_clk) begin
        if (r_rst_n) begin
            if (o_out_valid && r_out_ready) sb.check_word(o_out_word);
            if (r_in_valid && o_in_ready) sb.take_word(r_in_word);
        end
    end

    // receiver: random stalls, calm stretches, two long hold-offs
    initial begin
        int  stall;
        int  n_seen;
        bit  rx_calm;
        n_seen  = 0;
        rx_calm = 1'b0;
        wait (r_rst_n);
        forever begin
            @(negedge i_clk);
            if (n_seen == 60 || n_seen == 450)
                stall = 300;
            else
                stall = rx_calm ? 0 : $urandom_range(0, 6);
            if (stall > 0) begin
                r_out_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            r_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            n_seen++;
            if (n_seen % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
        end
    end

    task automatic send(input logic [1:0] kind, input logic [15:0] c, input logic [15:0] s,
                        input logic [31:0] a);
        t_in_word w;
        int       gap;
        w.req_type = kind;
        w.cos_in   = c;
        w.sin_in   = s;
        w.angle_in = a;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            r_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        r_in_valid <= 1'b1;
        r_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
        n_sent++;
        if (n_sent % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
    endtask

    function automatic logic [31:0] rand_delta();
        return $signed($urandom_range(0, 400000)) - 200000;
    endfunction

    initial begin
        int                 pick;
        logic signed [31:0] a;
        logic signed [15:0] c;
        logic signed [15:0] s;
        repeat (10) @(negedge i_clk);
        r_rst_n <= 1'b1;

        // quadrant steps, null vector, extremes of the pair
        send(REQ_PAIR, 16'sd16384, 16'sd0, $urandom);
        send(REQ_PAIR, 16'sd0, 16'sd16384, $urandom);
        send(REQ_PAIR, -16'sd16384, 16'sd0, $urandom);
        send(REQ_PAIR, 16'sd16384, 16'sd0, $urandom);   // half turn through the left plane
        send(REQ_PAIR, 16'sd0, 16'sd0, $urandom);
        send(REQ_PAIR, 16'sd12000, -16'sd9000, $urandom);
        send(REQ_PAIR, 16'sh8000, 16'sh8000, $urandom);
        send(REQ_PAIR, 16'sh7fff, 16'sh7fff, $urandom);
        send(REQ_PAIR, 16'sh8000, 16'sh7fff, $urandom);
        // climb past the top of the range
        send(REQ_LOAD, 16'($urandom), 16'($urandom), 32'h7fff_ffff);
        send(REQ_PAIR, 16'sd16384, 16'sd0, $urandom);
        send(REQ_PAIR, 16'sd0, 16'sd16384, $urandom);
        send(REQ_PAIR, -16'sd16384, 16'sd0, $urandom);
        send(REQ_PAIR, 16'sd0, -16'sd16384, $urandom);
        // descend past the bottom
        send(REQ_LOAD, 16'($urandom), 16'($urandom), 32'h8000_0000);
        send(REQ_PAIR, 16'sd0, -16'sd16384, $urandom);
        send(REQ_PAIR, -16'sd16384, 16'sd0, $urandom);
        send(REQ_PAIR, 16'sd0, 16'sd16384, $urandom);
        send(REQ_ANGLE, 16'($urandom), 16'($urandom), 32'h7fff_ffff);
        send(REQ_ANGLE, 16'($urandom), 16'($urandom), 32'h8000_0000);
        send(REQ_SPARE, 16'($urandom), 16'($urandom), $urandom);
        send(REQ_LOAD, 16'($urandom), 16'($urandom), 32'sd102944);
        send(REQ_LOAD, 16'($urandom), 16'($urandom), -32'sd205887);
        send(REQ_ANGLE, 16'($urandom), 16'($urandom), 32'sd308831);
        send(REQ_ANGLE, 16'($urandom), 16'($urandom), 32'sd0);

        // random walk of the angle, loads now and then, some noise words
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 350) begin
                r_in_valid <= 1'b0;
                do @(negedge i_clk); while (sb.pending() != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                case ($urandom_range(0, 9))
                    0:       a = 32'h7fff_ffff - $urandom_range(0, 300000);
                    1:       a = 32'h8000_0000 + $urandom_range(0, 300000);
                    2:       a = $urandom;
                    default: a = $signed($urandom_range(0, 823550)) - 411775;
                endcase
                walk = a;
                send(REQ_LOAD, 16'($urandom), 16'($urandom), a);
            end else if (pick < 55) begin
                if ($urandom_range(0, 9) < 7) begin
                    walk = walk + rand_delta();
                    sb.unit_pair(walk, c, s);
                    send(REQ_PAIR, c, s, $urandom);
                end else begin
                    send(REQ_PAIR, 16'($urandom), 16'($urandom), $urandom);
                end
            end else if (pick < 95) begin
                if ($urandom_range(0, 9) < 7) begin
                    walk = walk + rand_delta();
                    send(REQ_ANGLE, 16'($urandom), 16'($urandom), walk);
                end else begin
                    send(REQ_ANGLE, 16'($urandom), 16'($urandom), $urandom);
                end
            end else begin
                send(REQ_SPARE, 16'($urandom), 16'($urandom), $urandom);
            end
        end
        r_in_valid <= 1'b0;

        do @(negedge i_clk); while (sb.pending() != 0);
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
